### rtl/gamepad_serial_frame_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gamepad serial frame parser
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_SERIAL_FRAME_PARSER_CORE_ASSERT_SVH
`define GAMEPAD_SERIAL_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define GSFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gsfp_pkg.sv
// ----------------------------------------------------------------------------
// gsfp_pkg
// Frame constants and shared types of the gamepad serial frame parser.
// ----------------------------------------------------------------------------
package gsfp_pkg;

  localparam logic [7:0] HeadFirst  = 8'hAA;
  localparam logic [7:0] HeadSecond = 8'h55;
  localparam logic [7:0] FrameTail  = 8'h0D;

  // decoded frame contents
  typedef struct packed {
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [15:0] button_word;
    logic [7:0]  hat_x;
    logic [7:0]  hat_y;
    logic [7:0]  left_trigger;
    logic [7:0]  right_trigger;
  } gsfp_result_t;

  // good-frame strobe with its contents
  typedef struct packed {
    logic         valid;
    gsfp_result_t res;
  } gsfp_emit_t;

endpackage

### rtl/gsfp_frame_fsm.sv
// ----------------------------------------------------------------------------
// gsfp_frame_fsm
// Header hunt, body capture and running checksum for one frame.
// ----------------------------------------------------------------------------
module gsfp_frame_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output logic                last_o,
  output gsfp_pkg::gsfp_emit_t emit_o
);
  import gsfp_pkg::*;

  localparam logic [1:0] PhHead1 = 2'd0;
  localparam logic [1:0] PhHead2 = 2'd1;
  localparam logic [1:0] PhBody  = 2'd2;

  localparam logic [3:0] PosFirst = 4'd2;
  localparam logic [3:0] PosChk   = 4'd12;
  localparam logic [3:0] PosLast  = 4'd13;
  localparam int         PayDepth = 10;

  logic [1:0] phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] chk_q;
  logic [7:0] pay_q [PayDepth];

  logic       in_body;
  logic       body_pos;
  logic       pay_wr;
  logic       chk_wr;
  logic [3:0] wr_idx;

  assign in_body  = (phase_q == PhBody);
  assign body_pos = (pos_q >= PosFirst) && (pos_q < PosLast);
  assign last_o   = in_body && !body_pos;
  assign pay_wr   = accept_i && in_body && body_pos && (pos_q != PosChk);
  assign chk_wr   = accept_i && in_body && (pos_q == PosChk);
  assign wr_idx   = pos_q - PosFirst;

  // phase and position sequencing
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    if (accept_i) begin
      unique case (phase_q)
        PhHead1: begin
          if (rx_byte_i == HeadFirst) begin
            phase_d = PhHead2;
            pos_d   = 4'd1;
          end
        end
        PhHead2: begin
          if (rx_byte_i == HeadSecond) begin
            phase_d = PhBody;
            pos_d   = PosFirst;
          end else begin
            phase_d = PhHead1;
          end
        end
        PhBody: begin
          if (body_pos) begin
            pos_d = pos_q + 4'd1;
          end else begin
            phase_d = PhHead1;
            pos_d   = 4'd0;
          end
        end
        default: phase_d = PhHead1;
      endcase
    end
  end

  // running sum over payload bytes, restarted at the first one
  always_comb begin
    sum_d = sum_q;
    if (pay_wr) begin
      sum_d = (pos_q == PosFirst) ? rx_byte_i : sum_q + rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead1;
      pos_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // payload store, no reset
  always_ff @(posedge clk_i) begin
    if (pay_wr) begin
      sum_q <= sum_d;
    end
    if (chk_wr) begin
      chk_q <= rx_byte_i;
    end
    for (int i = 0; i < PayDepth; i++) begin
      if (pay_wr && (wr_idx == 4'(i))) begin
        pay_q[i] <= rx_byte_i;
      end
    end
  end

  // frame check on the tail byte
  always_comb begin
    emit_o.valid = accept_i && last_o && (rx_byte_i == FrameTail) && (sum_q == chk_q);
    emit_o.res.left_x        = pay_q[0];
    emit_o.res.left_y        = pay_q[1];
    emit_o.res.right_x       = pay_q[2];
    emit_o.res.right_y       = pay_q[3];
    emit_o.res.button_word   = {pay_q[4], pay_q[5]};
    emit_o.res.hat_x         = pay_q[6];
    emit_o.res.hat_y         = pay_q[7];
    emit_o.res.left_trigger  = pay_q[8];
    emit_o.res.right_trigger = pay_q[9];
  end

endmodule

### rtl/gsfp_out_reg.sv
// ----------------------------------------------------------------------------
// gsfp_out_reg
// Result register with valid/ready hold toward the receiver.
// ----------------------------------------------------------------------------
module gsfp_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gsfp_pkg::gsfp_emit_t   emit_i,
  input  logic                   out_ready_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  output gsfp_pkg::gsfp_result_t res_o
);
  import gsfp_pkg::*;

  logic         valid_q, valid_d;
  gsfp_result_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload loads only on a good frame
  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      res_q <= emit_i.res;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### rtl/gamepad_serial_frame_parser_core.sv
// ----------------------------------------------------------------------------
// gamepad_serial_frame_parser_core
// Parses 14-byte gamepad frames out of a received serial byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel: one received byte per item (rx_valid_i / rx_ready_o).
//   out channel: one decoded gamepad state per good frame
//   (out_valid_o / out_ready_i), fields on their own ports.
//   A frame is AA 55, ten payload bytes, checksum, 0D. A result appears
//   in the cycle after its tail byte is accepted; bad frames give nothing.
//   Throughput: one byte per cycle while no tail byte is held off. The header/body sequencer and a
//   running checksum finish each byte in the cycle it is taken, so only
//   the single result register limits the rate.
//   Stall: while a result waits and out_ready_i is low, bytes keep being
//   taken; only a tail byte is held off until the result register frees.
//   Reset: the parser waits for a first header byte, no result pending.
// ----------------------------------------------------------------------------
module gamepad_serial_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  left_x_o,
  output logic [7:0]  left_y_o,
  output logic [7:0]  right_x_o,
  output logic [7:0]  right_y_o,
  output logic [15:0] button_word_o,
  output logic [7:0]  hat_x_o,
  output logic [7:0]  hat_y_o,
  output logic [7:0]  left_trigger_o,
  output logic [7:0]  right_trigger_o
);
  import gsfp_pkg::*;

  logic         last;
  logic         space;
  logic         accept;
  gsfp_emit_t   emit;
  gsfp_result_t res;

  // only the tail byte needs room in the result register
  assign rx_ready_o = !last || space;
  assign accept     = rx_valid_i && rx_ready_o;

  gsfp_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .last_o    (last),
    .emit_o    (emit)
  );

  gsfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .out_ready_i (out_ready_i),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign left_x_o        = res.left_x;
  assign left_y_o        = res.left_y;
  assign right_x_o       = res.right_x;
  assign right_y_o       = res.right_y;
  assign button_word_o   = res.button_word;
  assign hat_x_o         = res.hat_x;
  assign hat_y_o         = res.hat_y;
  assign left_trigger_o  = res.left_trigger;
  assign right_trigger_o = res.right_trigger;

endmodule

### rtl/gsfp_checker.sv
// ----------------------------------------------------------------------------
// gsfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "gamepad_serial_frame_parser_core_assert.svh"

module gsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  left_x_o,
  input logic [7:0]  left_y_o,
  input logic [7:0]  right_x_o,
  input logic [7:0]  right_y_o,
  input logic [15:0] button_word_o,
  input logic [7:0]  hat_x_o,
  input logic [7:0]  hat_y_o,
  input logic [7:0]  left_trigger_o,
  input logic [7:0]  right_trigger_o
);
  import gsfp_pkg::*;

  logic [87:0] res_bits;
  logic        new_res;

  assign res_bits = {left_x_o, left_y_o, right_x_o, right_y_o, button_word_o,
                     hat_x_o, hat_y_o, left_trigger_o, right_trigger_o};
  // result on the port; freshness is qualified in the cause check below
  assign new_res  = out_valid_o;

  // a stalled result stays put
  `GSFP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `GSFP_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(res_bits), "result changed")

  // every new result follows an accepted tail byte
  `GSFP_ASSERT_IMPL(a_res_cause, new_res && !$past(out_valid_o && !out_ready_i), $past(rx_valid_i && rx_ready_o) && ($past(rx_byte_i) == FrameTail), "result without tail")

  // the result register never overruns: a stalled result stays put while rx is held off
  `GSFP_ASSERT_NEXT(a_no_overrun, out_valid_o && !out_ready_i && !rx_ready_o, out_valid_o && $stable(res_bits), "overrun")

endmodule

bind gamepad_serial_frame_parser_core gsfp_checker u_gsfp_checker (.*);
